// File: rtl/core/lqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqs_pkg: shared constants and types of the landmark quality score core
// Register indexes, the Q format default and the fixed field widths.
// ----------------------------------------------------------------------------
package lqs_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIST_W  = 20;
    localparam int BASE_W  = 16;
    localparam int MULT_W  = 16;
    localparam int CNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_LIMIT   = 3'd0,
        REG_NEAR_FLOOR   = 3'd1,
        REG_BASE_MULT    = 3'd2,
        REG_FAR_FALLBACK = 3'd3,
        REG_FAR_FLOOR    = 3'd4,
        REG_ISO_FLOOR    = 3'd5,
        REG_MIN_NEIGH    = 3'd6,
        REG_MIN_OBS_ISO  = 3'd7
    } t_reg_idx;
endpackage
`default_nettype wire

// File: rtl/core/lqs_frac_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lqs_frac_div: pipelined restoring fraction divider
// One quotient bit per stage; returns round(num * 2^F / den), half up.
// Items move in lockstep with their valid bit and carry a side word along.
// ----------------------------------------------------------------------------
module lqs_frac_div #(
    parameter int F   = 16,
    parameter int W   = 80,
    parameter int SW  = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [F:0]         o_quot,
    output logic [SW-1:0]      o_side
);
    localparam int N = F + 1;

    logic [W:0]    r_rem  [N];
    logic [W-1:0]  r_den  [N];
    logic [N-1:0]  r_q    [N];
    logic [SW-1:0] r_side [N];
    logic [N-1:0]  r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [W:0] t;
        t = {i_num, 1'b0};
        if (t >= {1'b0, i_den}) begin
            r_rem[0] <= t - {1'b0, i_den};
            r_q[0]   <= N'(1);
        end else begin
            r_rem[0] <= t;
            r_q[0]   <= '0;
        end
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int s = 1; s < N; s++) begin
            t = {r_rem[s-1][W-1:0], 1'b0};
            if (t >= {1'b0, r_den[s-1]}) begin
                r_rem[s] <= t - {1'b0, r_den[s-1]};
                r_q[s]   <= {r_q[s-1][N-2:0], 1'b1};
            end else begin
                r_rem[s] <= t;
                r_q[s]   <= {r_q[s-1][N-2:0], 1'b0};
            end
            r_den[s]  <= r_den[s-1];
            r_side[s] <= r_side[s-1];
        end
    end

    logic [N:0] w_rnd;
    assign w_rnd   = {1'b0, r_q[N-1]} + (N+1)'(1);
    assign o_quot  = w_rnd[N:1];
    assign o_valid = r_vld[N-1];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

// File: rtl/core/landmark_quality_score_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// landmark_quality_score_core: per-landmark quality score pipeline
// Base score, range factor, isolation factor, product and clamp, one
// landmark per clock.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  input     | i_start & !o_busy      | i_observation_total .. i_minus_adjustment
//  config    | i_cfg_valid&o_cfg_ready| i_cfg_index, i_cfg_data
//  result    | o_strobe (one cycle)   | o_final_score .. o_isolation_factor_out
//
//  One word is accepted every cycle. Two bit-per-stage dividers (range ratio and
//  isolation ratio) run side by side and set the depth: two front stages,
//  FRAC_BITS + 1 divider stages, four back stages.
//  o_busy is held low: the result side cannot stall, so nothing backs up.
//  Reset (synchronous, active low) clears the valid bits and sets the
//  configuration registers to their reset values: multiplier 256, far fallback 100, the rest zero.
// ----------------------------------------------------------------------------
module landmark_quality_score_core #(
    parameter int FRAC_BITS = lqs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [lqs_pkg::CNT_W-1:0]     i_observation_total,
    input  wire logic [FRAC_BITS:0]            i_found_fraction,
    input  wire logic                          i_descriptor_ok,
    input  wire logic                          i_point_bad,
    input  wire logic                          i_has_geometry,
    input  wire logic                          i_distance_valid,
    input  wire logic [lqs_pkg::DIST_W-1:0]    i_observer_distance_mm,
    input  wire logic [lqs_pkg::BASE_W-1:0]    i_baseline_mm,
    input  wire logic [lqs_pkg::CNT_W-1:0]     i_neighbour_total,
    input  wire logic [FRAC_BITS+4:0]          i_plus_adjustment,
    input  wire logic signed [FRAC_BITS+4:0]   i_minus_adjustment,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lqs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lqs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                               o_strobe,
    output logic [FRAC_BITS:0]                 o_final_score,
    output logic [FRAC_BITS:0]                 o_base_score,
    output logic [FRAC_BITS:0]                 o_range_factor,
    output logic [FRAC_BITS:0]                 o_isolation_factor_out
);
    import lqs_pkg::*;

    localparam int Q   = FRAC_BITS + 1;
    localparam int AW  = FRAC_BITS + 5;
    localparam logic [Q-1:0] ONE = Q'(1) << FRAC_BITS;
    // far limit in Q24.8 mm: 32 bits; squared: 64 bits
    localparam int FW  = MULT_W + BASE_W;
    localparam int DW  = 2 * FW;
    // isolation divider: (1 - floor) * neighbours over min_neighbours << FRAC_BITS
    localparam int IW  = CNT_W + Q;
    // side word carried through the ratio divider
    localparam int SW  = 2 + Q + AW + AW;
    // divide by 800 as a shift by 5 and a reciprocal multiply by 1/25
    localparam int RK  = Q + 10;
    localparam logic [RK-5:0] RECIP25 = (RK-4)'(((longint'(1) << RK) + 24) / 25);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] r_near_limit, r_far_fb;
    logic [Q-1:0]      r_near_floor, r_far_floor, r_iso_floor;
    logic [MULT_W-1:0] r_mult;
    logic [CNT_W-1:0]  r_min_nb, r_min_obs;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_limit <= '0;
            r_near_floor <= '0;
            r_mult       <= MULT_W'(256);
            r_far_fb     <= DIST_W'(100);
            r_far_floor  <= '0;
            r_iso_floor  <= '0;
            r_min_nb     <= '0;
            r_min_obs    <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_NEAR_LIMIT:   r_near_limit <= i_cfg_data[DIST_W-1:0];
                REG_NEAR_FLOOR:   r_near_floor <= i_cfg_data[Q-1:0];
                REG_BASE_MULT:    r_mult       <= i_cfg_data[MULT_W-1:0];
                REG_FAR_FALLBACK: r_far_fb     <= i_cfg_data[DIST_W-1:0];
                REG_FAR_FLOOR:    r_far_floor  <= i_cfg_data[Q-1:0];
                REG_ISO_FLOOR:    r_iso_floor  <= i_cfg_data[Q-1:0];
                REG_MIN_NEIGH:    r_min_nb     <= i_cfg_data[CNT_W-1:0];
                REG_MIN_OBS_ISO:  r_min_obs    <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [Q-1:0] sat1(input logic [Q-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    // ------------------------------------------------------------------
    // stage 1: base numerator, far limit, range-case decode
    // ------------------------------------------------------------------
    logic              w_acc;
    assign w_acc = i_start & ~o_busy;

    logic              r1_vld;
    logic [Q+10-1:0]   r1_bnum;
    logic              r1_bad;
    logic [1:0]        r1_rcase;  // 0: one, 1: near, 2: far
    logic [DIST_W-1:0] r1_dist;
    logic [FW-1:0]     r1_far;
    logic              r1_iso_on;
    logic [CNT_W-1:0]  r1_nb;
    logic [AW-1:0]     r1_plus;
    logic [AW-1:0]     r1_minus;

    localparam logic [1:0] RC_ONE = 2'd0, RC_NEAR = 2'd1, RC_FAR = 2'd2;

    always_ff @(posedge i_clk) begin
        logic [3:0]        o8;
        logic [Q-1:0]      fnd;
        logic [FW-1:0]     mult, fb, far, nl8, d8;
        logic              geo_ok;
        o8   = (i_observation_total > CNT_W'(8)) ? 4'd8 : i_observation_total[3:0];
        fnd  = sat1(i_found_fraction);
        r1_bnum <= (Q+10)'(55 * o8) * (Q+10)'(ONE) + (Q+10)'(280) * (Q+10)'(fnd)
                 + (i_descriptor_ok ? (Q+10)'(80) * (Q+10)'(ONE) : '0)
                 + (Q+10)'(400);
        r1_bad <= i_point_bad;
        mult = (r_mult < MULT_W'(256)) ? FW'(256) : FW'(r_mult);
        fb   = (r_far_fb < DIST_W'(100)) ? FW'(100) : FW'(r_far_fb);
        nl8  = FW'(r_near_limit) << 8;
        if (i_baseline_mm != '0) begin
            far = FW'(mult[MULT_W-1:0]) * FW'(i_baseline_mm);
            if (far < nl8) far = nl8;
        end else begin
            far = fb << 8;
        end
        d8 = FW'(i_observer_distance_mm) << 8;
        geo_ok = i_has_geometry & i_distance_valid;
        if (!geo_ok)
            r1_rcase <= RC_ONE;
        else if (r_near_limit != '0 && i_observer_distance_mm < r_near_limit)
            r1_rcase <= RC_NEAR;
        else if (d8 <= far)
            r1_rcase <= RC_ONE;
        else
            r1_rcase <= RC_FAR;
        r1_far  <= far;
        r1_dist <= i_observer_distance_mm;
        r1_iso_on <= i_has_geometry && !(i_observation_total < r_min_obs)
                  && r_min_nb != '0 && i_neighbour_total < r_min_nb;
        r1_nb    <= i_neighbour_total;
        r1_plus  <= i_plus_adjustment;
        r1_minus <= i_minus_adjustment;
    end

    // ------------------------------------------------------------------
    // stage 2: base divide by 800, squares for the divider, iso numerator
    // ------------------------------------------------------------------
    logic          r2_vld;
    logic [DW-1:0] r2_num, r2_den;
    logic [1:0]    r2_rcase;
    logic [Q-1:0]  r2_base;
    logic          r2_iso_on;
    logic [IW-1:0] r2_inum, r2_iden;
    logic [AW-1:0] r2_plus, r2_minus;

    always_ff @(posedge i_clk) begin
        logic [Q-1:0]      f;
        logic [Q+4:0]      y;
        logic [2*Q+10:0]   pr;
        logic [Q:0]        b;
        y  = r1_bnum[Q+9:5];
        pr = (2*Q+11)'(y) * (2*Q+11)'(RECIP25);
        b  = pr[2*Q+10:RK];
        r2_base <= r1_bad ? '0 : ((b > (Q+1)'(ONE)) ? ONE : b[Q-1:0]);
        if (r1_rcase == RC_NEAR) begin
            r2_num <= r1_dist * r1_dist;
            r2_den <= r_near_limit * r_near_limit;
        end else begin
            r2_num <= r1_far * r1_far;
            r2_den <= {r1_dist, 8'd0} * {r1_dist, 8'd0};
        end
        r2_rcase  <= r1_rcase;
        f = sat1(r_iso_floor);
        r2_inum <= IW'(ONE - f) * IW'(r1_nb);
        r2_iden <= IW'({r_min_nb, {FRAC_BITS{1'b0}}});
        r2_iso_on <= r1_iso_on;
        r2_plus <= r1_plus;
        r2_minus <= r1_minus;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= w_acc;
            r2_vld <= r1_vld;
        end
    end

    // ------------------------------------------------------------------
    // ratio dividers: range ratio and isolation ratio in lockstep
    // ------------------------------------------------------------------
    logic          d_vld;
    logic [Q-1:0]  d_q;
    logic [SW-1:0] d_side;
    logic          di_vld;
    logic [Q-1:0]  di_q;
    logic          di_on;

    lqs_frac_div #(.F(FRAC_BITS), .W(DW), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  ({r2_rcase, r2_base, r2_plus, r2_minus}),
        .o_valid (d_vld),
        .o_quot  (d_q),
        .o_side  (d_side)
    );

    // round((1 - floor) * nb / min_nb) as a fraction of min_nb << FRAC_BITS
    lqs_frac_div #(.F(FRAC_BITS), .W(IW), .SW(1)) u_iso_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (r2_inum),
        .i_den   (r2_iden),
        .i_side  (r2_iso_on),
        .o_valid (di_vld),
        .o_quot  (di_q),
        .o_side  (di_on)
    );

    logic [1:0]    s_rc;
    logic [Q-1:0]  s_base;
    logic [AW-1:0] s_plus, s_minus;
    assign {s_rc, s_base, s_plus, s_minus} = d_side;

    // ------------------------------------------------------------------
    // stage A: range floor, iso sum; stage B: base*range; stage C: *iso;
    // stage D: sum and clamp
    // ------------------------------------------------------------------
    logic          ra_vld, rb_vld, rc_vld, rd_vld;
    logic [Q-1:0]  ra_range, ra_base, ra_iso;
    logic [AW-1:0] ra_plus, ra_minus;
    logic [Q-1:0]  rb_p, rb_range, rb_base, rb_iso;
    logic [AW-1:0] rb_plus, rb_minus;
    logic [Q-1:0]  rc_p, rc_range, rc_base, rc_iso;
    logic [AW-1:0] rc_plus, rc_minus;

    always_ff @(posedge i_clk) begin
        logic [Q-1:0] fl;
        logic [Q:0] isum;
        logic [2*Q-1:0] m;
        logic signed [AW+2:0] tot;
        fl = (s_rc == RC_NEAR) ? sat1(r_near_floor) : sat1(r_far_floor);
        if (s_rc == RC_ONE) ra_range <= ONE;
        else ra_range <= (d_q < fl) ? fl : d_q;
        isum = {1'b0, sat1(r_iso_floor)} + {1'b0, di_q};
        ra_iso <= di_on ? ((isum > (Q+1)'(ONE)) ? ONE : isum[Q-1:0]) : ONE;
        ra_base <= s_base;
        ra_plus <= s_plus; ra_minus <= s_minus;

        m = ra_base * ra_range + (2*Q)'(ONE >> 1);
        rb_p <= m[FRAC_BITS +: Q];
        rb_range <= ra_range; rb_base <= ra_base; rb_iso <= ra_iso;
        rb_plus <= ra_plus; rb_minus <= ra_minus;

        m = rb_p * rb_iso + (2*Q)'(ONE >> 1);
        rc_p <= m[FRAC_BITS +: Q];
        rc_range <= rb_range; rc_base <= rb_base; rc_iso <= rb_iso;
        rc_plus <= rb_plus; rc_minus <= rb_minus;

        tot = $signed({3'b0, AW'(rc_p)}) + $signed({3'b0, rc_plus})
            + $signed({{3{rc_minus[AW-1]}}, rc_minus});
        if (tot < 0) o_final_score <= '0;
        else if (tot > $signed((AW+3)'(ONE))) o_final_score <= ONE;
        else o_final_score <= tot[Q-1:0];
        o_base_score <= rc_base;
        o_range_factor <= rc_range;
        o_isolation_factor_out <= rc_iso;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0; rb_vld <= 1'b0; rc_vld <= 1'b0; rd_vld <= 1'b0;
        end else begin
            ra_vld <= d_vld; rb_vld <= ra_vld; rc_vld <= rb_vld; rd_vld <= rc_vld;
        end
    end
    assign o_strobe = rd_vld;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rc_vld |=> o_strobe) else $error("result word lost");
    a_final_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_final_score <= ONE) else $error("final score over one");
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_range_factor <= ONE && o_isolation_factor_out <= ONE))
        else $error("factor over one");
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld == di_vld) else $error("dividers out of step");
endmodule
`default_nettype wire

// File: test/tb_landmark_quality_score_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_landmark_quality_score_core: self-checking bench of the landmark score core
// Drives scored landmarks through the input ports and predicts base, range,
// isolation and final score for each word; checks every strobed result in order
// under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_landmark_quality_score_core;
    import lqs_pkg::*;

    localparam int FB = 16;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam int LATENCY = FB + 9;
    localparam int WATCHDOG = 20000;

    // one landmark word as presented on the input ports
    typedef struct {
        logic [7:0]         obs;
        logic [FB:0]        found;
        logic               desc;
        logic               bad;
        logic               geo;
        logic               dvalid;
        logic [19:0]        dist_mm;
        logic [15:0]        bmm;
        logic [7:0]         nb;
        logic [FB+4:0]      plus;
        logic signed [FB+4:0] minus;
    } t_landmark;

    typedef struct {
        logic [FB:0] final_s;
        logic [FB:0] base_s;
        logic [FB:0] range_f;
        logic [FB:0] iso_f;
    } t_score;

    // register image kept by the bench
    longint unsigned near_mm, near_floor, mult, fallback, far_floor, iso_floor;
    longint unsigned min_nb, min_obs_iso;

    int mismatches = 0;

    function automatic longint unsigned sat1(longint unsigned v);
        return v > ONE ? ONE : v;
    endfunction

    // exact long division of a ratio below one, then round half up
    function automatic longint unsigned ratio_q(longint unsigned num,
                                                longint unsigned den);
        longint unsigned rem, q;
        rem = num;
        q = 0;
        for (int i = 0; i < FB + 1; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 1;
            end
        end
        return (q + 1) >> 1;
    endfunction

    function automatic longint unsigned range_factor_of(longint unsigned d,
                                                        longint unsigned b);
        longint unsigned m, fbk, far_q8, d_q8, r;
        m = mult < 256 ? 256 : mult;
        fbk = fallback < 100 ? 100 : fallback;
        if (near_mm > 0 && d < near_mm) begin
            r = ratio_q(d * d, near_mm * near_mm);
            return r < sat1(near_floor) ? sat1(near_floor) : r;
        end
        if (b > 0) begin
            far_q8 = m * b;
            if (far_q8 < (near_mm << 8)) far_q8 = near_mm << 8;
        end else begin
            far_q8 = fbk << 8;
        end
        d_q8 = d << 8;
        if (d_q8 <= far_q8) return ONE;
        r = ratio_q(far_q8 * far_q8, d_q8 * d_q8);
        return r < sat1(far_floor) ? sat1(far_floor) : r;
    endfunction

    function automatic t_score score_landmark(t_landmark w);
        t_score s;
        longint unsigned base, rng, iso, prod, o, num, f;
        longint signed total;
        if (w.bad) begin
            base = 0;
        end else begin
            o = w.obs > 8 ? 8 : w.obs;
            num = 55 * o * ONE + 280 * sat1(w.found) + 80 * w.desc * ONE;
            base = sat1((num + 400) / 800);
        end
        if (!w.geo || !w.dvalid) rng = ONE;
        else rng = range_factor_of(w.dist_mm, w.bmm);
        if (!w.geo || w.obs < min_obs_iso || min_nb == 0 || w.nb >= min_nb) begin
            iso = ONE;
        end else begin
            f = sat1(iso_floor);
            iso = sat1(f + (((ONE - f) * w.nb * 2 + min_nb) / (2 * min_nb)));
        end
        prod = (base * rng + (ONE >> 1)) >> FB;
        prod = (prod * iso + (ONE >> 1)) >> FB;
        total = longint'(prod) + longint'(w.plus) + longint'(w.minus);
        if (total < 0) total = 0;
        if (total > longint'(ONE)) total = ONE;
        s.final_s = total[FB:0];
        s.base_s = base[FB:0];
        s.range_f = rng[FB:0];
        s.iso_f = iso[FB:0];
        return s;
    endfunction

    // holds pending scores in acceptance order and checks strobed results
    class score_board;
        t_score pending[$];
        int checked;

        function void note_landmark(t_score s);
            pending.insert(pending.size(), s);
        endfunction

        function void check_result(t_score got);
            t_score want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result final=%0d", got.final_s);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.final_s !== want.final_s || got.base_s !== want.base_s ||
                got.range_f !== want.range_f || got.iso_f !== want.iso_f) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want f=%0d b=%0d r=%0d i=%0d got f=%0d b=%0d r=%0d i=%0d",
                             want.final_s, want.base_s, want.range_f, want.iso_f,
                             got.final_s, got.base_s, got.range_f, got.iso_f);
            end
        endfunction
    endclass

    score_board board;

    logic i_clk, i_rst_n, i_start, o_busy;
    logic [7:0] i_observation_total, i_neighbour_total;
    logic [FB:0] i_found_fraction;
    logic i_descriptor_ok, i_point_bad, i_has_geometry, i_distance_valid;
    logic [19:0] i_observer_distance_mm;
    logic [15:0] i_baseline_mm;
    logic [FB+4:0] i_plus_adjustment;
    logic signed [FB+4:0] i_minus_adjustment;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic o_strobe;
    logic [FB:0] o_final_score, o_base_score, o_range_factor, o_isolation_factor_out;

    landmark_quality_score_core #(.FRAC_BITS(FB)) i_dut (.*);

    int idle_pct = 0;
    int idle_cycles = 0;
    int landmarks_sent = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // check each strobed result and watch for a stalled run
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_result('{o_final_score, o_base_score, o_range_factor,
                                 o_isolation_factor_out});
        end
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_strobe)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d pending", board.pending.size());
            $display("tb_landmark_quality_score_core: errors");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, longint unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[31:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_NEAR_LIMIT:   near_mm = val & 20'hFFFFF;
            REG_NEAR_FLOOR:   near_floor = val & ((ONE << 1) - 1);
            REG_BASE_MULT:    mult = val & 16'hFFFF;
            REG_FAR_FALLBACK: fallback = val & 20'hFFFFF;
            REG_FAR_FLOOR:    far_floor = val & ((ONE << 1) - 1);
            REG_ISO_FLOOR:    iso_floor = val & ((ONE << 1) - 1);
            REG_MIN_NEIGH:    min_nb = val & 8'hFF;
            REG_MIN_OBS_ISO:  min_obs_iso = val & 8'hFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drive one landmark word; start stays high across back-to-back words
    task automatic send_landmark(t_landmark w);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_observation_total <= w.obs;
        i_found_fraction <= w.found;
        i_descriptor_ok <= w.desc;
        i_point_bad <= w.bad;
        i_has_geometry <= w.geo;
        i_distance_valid <= w.dvalid;
        i_observer_distance_mm <= w.dist_mm;
        i_baseline_mm <= w.bmm;
        i_neighbour_total <= w.nb;
        i_plus_adjustment <= w.plus;
        i_minus_adjustment <= w.minus;
        do @(posedge i_clk); while (o_busy);
        board.note_landmark(score_landmark(w));
        landmarks_sent++;
        @(negedge i_clk);
    endtask

    // drop start and hold until every pending score has come back
    task automatic drain;
        i_start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic t_landmark rand_landmark();
        t_landmark w;
        w.obs = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(10));
        w.found = 17'(($urandom_range(7) == 0) ? $urandom_range(131071)
                                               : $urandom_range(65536));
        w.desc = 1'($urandom_range(1));
        w.bad = ($urandom_range(7) == 0);
        w.geo = ($urandom_range(7) != 0);
        w.dvalid = ($urandom_range(7) != 0);
        case ($urandom_range(3))
            0: w.dist_mm = 20'($urandom_range(1048575));
            1: w.dist_mm = 20'($urandom_range(5000));
            2: w.dist_mm = 20'($urandom_range(200000));
            default: w.dist_mm = 20'($urandom_range(1000));
        endcase
        w.bmm = 16'(($urandom_range(3) == 0) ? 0 :
                (($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(300)));
        w.nb = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12));
        w.plus = 21'(($urandom_range(1) == 0) ? 0 :
                 (($urandom_range(7) == 0) ? $urandom_range(2097151) : $urandom_range(20000)));
        case ($urandom_range(3))
            0: w.minus = '0;
            1: w.minus = 21'(-$urandom_range(20000));
            2: w.minus = 21'($urandom_range(2097151));
            default: w.minus = 21'(-$urandom_range(1048576));
        endcase
        return w;
    endfunction

    task automatic random_phase(int n, int pct);
        idle_pct = pct;
        repeat (n) send_landmark(rand_landmark());
        drain();
    endtask

    task automatic random_config();
        write_reg(REG_NEAR_LIMIT, $urandom_range(3) == 0 ? 0 : $urandom_range(3000));
        write_reg(REG_NEAR_FLOOR, $urandom_range(131071));
        write_reg(REG_BASE_MULT, $urandom_range(65535));
        write_reg(REG_FAR_FALLBACK, $urandom_range(200000));
        write_reg(REG_FAR_FLOOR, $urandom_range(131071));
        write_reg(REG_ISO_FLOOR, $urandom_range(131071));
        write_reg(REG_MIN_NEIGH, $urandom_range(3) == 0 ? 0 : $urandom_range(20));
        write_reg(REG_MIN_OBS_ISO, $urandom_range(6));
    endtask

    initial begin
        t_landmark w;
        board = new();
        near_mm = 0; near_floor = 0; mult = 256; fallback = 100;
        far_floor = 0; iso_floor = 0; min_nb = 0; min_obs_iso = 0;
        i_rst_n = 0; i_start = 0; i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_observation_total = '0; i_found_fraction = '0; i_descriptor_ok = 1'b0;
        i_point_bad = 1'b0; i_has_geometry = 1'b0; i_distance_valid = 1'b0;
        i_observer_distance_mm = '0; i_baseline_mm = '0; i_neighbour_total = '0;
        i_plus_adjustment = '0; i_minus_adjustment = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: defaults first, then a setting that exercises every branch
        w = '{8'd8, 17'd65536, 1'b1, 1'b0, 1'b1, 1'b1, 20'd50, 16'd0, 8'd0, 21'd0, 21'sd0};
        send_landmark(w);
        w = '{8'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, 20'd0, 16'd0, 8'd0, 21'd0, 21'sd0};
        send_landmark(w);
        w = '{8'd255, 17'h1FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 20'hFFFFF, 16'hFFFF, 8'd255,
              21'h1FFFFF, 21'sh0FFFFF};
        send_landmark(w);
        drain();
        write_reg(REG_NEAR_LIMIT, 1000);
        write_reg(REG_NEAR_FLOOR, 17'h1FFFF);
        write_reg(REG_BASE_MULT, 100);
        write_reg(REG_FAR_FALLBACK, 50);
        write_reg(REG_FAR_FLOOR, 5000);
        write_reg(REG_ISO_FLOOR, 20000);
        write_reg(REG_MIN_NEIGH, 10);
        write_reg(REG_MIN_OBS_ISO, 3);
        w = '{8'd5, 17'd30000, 1'b1, 1'b0, 1'b1, 1'b1, 20'd400, 16'd50, 8'd4, 21'd0, 21'sd0};
        send_landmark(w);                         // near, floor over one
        w.dist_mm = 20'd3000; send_landmark(w);   // far limit held at near limit
        w.bmm = 16'd0; w.dist_mm = 20'd150; send_landmark(w); // near, zero baseline
        w.dist_mm = 20'hFFFFF; send_landmark(w);  // far floor
        w.bad = 1'b1; w.plus = 21'd40000; w.minus = -21'sd10000; send_landmark(w);
        w.bad = 1'b0; w.obs = 8'd2; send_landmark(w); // below isolation obs threshold
        w.obs = 8'd3; w.nb = 8'd0; send_landmark(w);
        w.nb = 8'd10; send_landmark(w);
        w.dvalid = 1'b0; send_landmark(w);
        w.geo = 1'b0; w.dvalid = 1'b1; send_landmark(w);
        w.minus = 21'sd5000; send_landmark(w);    // positive minus adjustment
        w.minus = 21'h100000; w.plus = 21'd0; send_landmark(w);
        w.found = 17'h1FFFF; send_landmark(w);
        drain();
        write_reg(REG_NEAR_FLOOR, 0);
        write_reg(REG_FAR_FLOOR, 17'h1FFFF);
        write_reg(REG_ISO_FLOOR, 17'h10000);
        write_reg(REG_BASE_MULT, 65535);
        write_reg(REG_NEAR_LIMIT, 20'hFFFFF);
        write_reg(REG_FAR_FALLBACK, 20'hFFFFF);
        write_reg(REG_MIN_NEIGH, 255);
        write_reg(REG_MIN_OBS_ISO, 255);
        w = '{8'd255, 17'd1, 1'b0, 1'b0, 1'b1, 1'b1, 20'd1, 16'd1, 8'd254, 21'd0, 21'sd0};
        send_landmark(w);
        w.dist_mm = 20'hFFFFE; send_landmark(w);
        drain();

        // random phases across settings and idle patterns
        random_config(); random_phase(180, 16);
        random_config(); random_phase(180, 81);
        random_config(); random_phase(180, 0);
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("covered %0d landmarks, %0d results checked, extreme and random registers",
                 landmarks_sent, board.checked);
        if (mismatches == 0 && board.pending.size() == 0) begin
            $display("tb_landmark_quality_score_core: clean");
        end else begin
            $display("%0d mismatches, %0d scores never returned", mismatches,
                     board.pending.size());
            $display("tb_landmark_quality_score_core: errors");
        end
        $finish;
    end
endmodule
